// ----- src/b64u_pkg.sv -----
// Shared types, constants and the symbol-to-ASCII map for the base64url encoder.
package b64u_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] DashChar  = 8'h2D;  // '-'
  localparam logic [7:0] UnderChar = 8'h5F;  // '_'

  localparam logic [1:0] Phase0 = 2'd0;
  localparam logic [1:0] Phase1 = 2'd1;
  localparam logic [1:0] Phase2 = 2'd2;

  // One input byte: up to four characters to emit, in order.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      cnt_m1;  // characters in this word minus one
    logic            last;    // final character closes the message
  } job_t;

  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, v};
    if (v < 6'd26) begin
      r = 8'h41 + w;
    end else if (v < 6'd52) begin
      r = 8'h47 + w;
    end else if (v < 6'd62) begin
      r = w - 8'h04;
    end else if (v == 6'd62) begin
      r = DashChar;
    end else begin
      r = UnderChar;
    end
    return r;
  endfunction

endpackage

// ----- src/b64u_front.sv -----
// Front end: accepts bytes, tracks the group phase and builds the character word.
module b64u_front import b64u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output logic       job_valid_o,
  input  logic       job_ready_i,
  output job_t       job_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [1:0] nph;
  logic [3:0] ncb;
  logic       accept;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i && job_ready_i;

  always_comb begin
    job_o.chars  = {PadChar, PadChar, PadChar, PadChar};
    job_o.cnt_m1 = 2'd0;
    job_o.last   = end_of_message_i;
    case (phase_q)
      Phase1: begin
        job_o.chars[0] = sym_char({carry_q[1:0], data_byte_i[7:4]});
        ncb = data_byte_i[3:0];
        nph = Phase2;
      end
      Phase2: begin
        job_o.chars[0] = sym_char({carry_q, data_byte_i[7:6]});
        job_o.chars[1] = sym_char(data_byte_i[5:0]);
        job_o.cnt_m1   = 2'd1;
        ncb = 4'd0;
        nph = Phase0;
      end
      default: begin
        // an unreachable phase three behaves as phase zero
        job_o.chars[0] = sym_char(data_byte_i[7:2]);
        ncb = {2'b00, data_byte_i[1:0]};
        nph = Phase1;
      end
    endcase

    phase_d = nph;
    carry_d = ncb;
    if (end_of_message_i) begin
      // flush the partial group and pad to four characters
      if (nph == Phase1) begin
        job_o.chars[1] = sym_char({ncb[1:0], 4'b0000});
        job_o.cnt_m1   = 2'd3;
      end else if (nph == Phase2) begin
        job_o.chars[1] = sym_char({ncb, 2'b00});
        job_o.cnt_m1   = 2'd2;
      end
      phase_d = Phase0;
      carry_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= Phase0;
      carry_q <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

// ----- src/b64u_queue.sv -----
// Short FIFO of character words between the front end and the output sequencer.
module b64u_queue import b64u_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- src/b64u_back.sv -----
// Back end: walks each character word and drives one character per cycle while the output is not stalled.
module b64u_back import b64u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  job_t       job_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  job_t       cur_q;
  logic       cur_vld_q;
  logic [1:0] idx_q;
  logic       out_vld_q;
  logic [7:0] out_char_q;
  logic       out_last_q;
  logic       load_out, done;

  assign load_out    = cur_vld_q && (!out_vld_q || out_ready_i);
  assign done        = load_out && (idx_q == cur_q.cnt_m1);
  assign job_ready_o = !cur_vld_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (job_valid_i && job_ready_o) begin
        cur_vld_q <= 1'b1;
        idx_q     <= 2'd0;
      end else if (done) begin
        cur_vld_q <= 1'b0;
      end else if (load_out) begin
        idx_q <= idx_q + 2'd1;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      cur_q <= job_i;
    end
    if (load_out) begin
      out_char_q <= cur_q.chars[idx_q];
      out_last_q <= cur_q.last && done;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

// ----- src/base64url_stream_encoder.sv -----
// Top level of the base64url stream encoder with '=' padding.
//
//   channel | direction | signals
//   --------+-----------+-----------------------------------------------------
//   input   | in        | in_valid_i, in_ready_o, data_byte_i, end_of_message_i
//   output  | out       | out_valid_o, out_ready_i, out_char_o, last_char_o
//
// A byte yields one to four characters, and the character sequencer emits one
// per cycle while the output is not stalled: four characters per three bytes
// sustained, plus the padding characters at the end of a message.
// The front end takes a byte in the cycle it arrives while the word queue
// has room; stalls on the output only back up through the queue.
// Reset clears the group phase, the carried bits, the queue and the output.
module base64url_stream_encoder import b64u_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  logic fq_valid, fq_ready;
  job_t fq_job;
  logic qb_valid, qb_ready;
  job_t qb_job;

  b64u_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .job_valid_o      (fq_valid),
    .job_ready_i      (fq_ready),
    .job_o            (fq_job)
  );

  b64u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_job)
  );

  b64u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// ----- src/b64u_checker.sv -----
// Port-level checks for the base64url encoder, bound to the top level.
module b64u_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       last_char_o
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o)
      && $stable(last_char_o))
    else $error("output word changed while stalled");

  // every character is from the URL-safe alphabet or the pad
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_char_o >= 8'h41 && out_char_o <= 8'h5A)
      || (out_char_o >= 8'h61 && out_char_o <= 8'h7A)
      || (out_char_o >= 8'h30 && out_char_o <= 8'h39)
      || out_char_o == 8'h2D || out_char_o == 8'h5F || out_char_o == 8'h3D)
    else $error("character outside the base64url set");

  // keep the output idle while reset is held
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // no word appears on the output in the cycle after reset releases
  a_first_cycle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind base64url_stream_encoder b64u_checker u_b64u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_char_o  (out_char_o),
  .last_char_o (last_char_o)
);

// ----- dv/base64url_stream_encoder_test.sv -----
// Self-checking testbench for the base64url stream encoder: directed table plus random messages.
module base64url_stream_encoder_test import b64u_pkg::*;;

  localparam int unsigned TotalBytes = 310;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned NumDirected = 22;
  localparam int unsigned MaxReports = 10;

  // One row of the directed table; typed_n of zero leaves the row to the predictor.
  typedef struct packed {
    logic [7:0]  data;
    logic        eom;
    logic [2:0]  typed_n;
    logic [31:0] typed;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  localparam stim_row_t DirRows [NumDirected] = '{
    '{8'h00, 1'b1, 3'd4, "AA=="},
    '{8'hFF, 1'b1, 3'd4, "_w=="},
    '{8'hFF, 1'b0, 3'd1, "_   "},
    '{8'hFF, 1'b0, 3'd1, "_   "},
    '{8'hFF, 1'b1, 3'd2, "__  "},
    '{8'hFB, 1'b0, 3'd1, "-   "},
    '{8'hEF, 1'b0, 3'd1, "-   "},
    '{8'hBE, 1'b1, 3'd2, "--  "},
    '{8'h00, 1'b0, 3'd1, "A   "},
    '{8'h00, 1'b1, 3'd3, "AA= "},
    '{8'h00, 1'b0, 3'd1, "A   "},
    '{8'h00, 1'b0, 3'd1, "A   "},
    '{8'h00, 1'b1, 3'd2, "AA  "},
    '{8'h4D, 1'b0, 3'd0, 32'h0},
    '{8'h61, 1'b0, 3'd0, 32'h0},
    '{8'h6E, 1'b0, 3'd0, 32'h0},
    '{8'hFC, 1'b1, 3'd0, 32'h0},
    '{8'hD3, 1'b0, 3'd0, 32'h0},
    '{8'h4D, 1'b0, 3'd0, 32'h0},
    '{8'h35, 1'b0, 3'd0, 32'h0},
    '{8'h01, 1'b1, 3'd0, 32'h0},
    '{8'h80, 1'b1, 3'd0, 32'h0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       end_of_message_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_char_o;
  logic       last_char_o;

  // encoder state tracked by the predictor
  logic [1:0] enc_phase = Phase0;
  logic [3:0] enc_carry = 4'd0;
  logic [7:0] pred_chars [4];
  int         pred_n;

  enc_char_t   pending_chars [$];
  logic [2:0]  row_typed_n;
  logic [31:0] row_typed;
  bit          sender_calm;
  bit          held_off;
  int          bytes_sent;
  int          msgs_seen = 0;
  int          chars_checked = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  base64url_stream_encoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_char_o      (out_char_o),
    .last_char_o     (last_char_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] url_symbol(input logic [5:0] v);
    if (v < 6'd26) return "A" + v;
    else if (v < 6'd52) return "a" + v - 8'd26;
    else if (v < 6'd62) return "0" + v - 8'd52;
    else if (v == 6'd62) return DashChar;
    else return UnderChar;
  endfunction

  // Advance the predictor by one byte; leaves the characters in pred_chars.
  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    pred_n = 0;
    case (enc_phase)
      Phase1: begin
        pred_chars[0] = url_symbol({enc_carry[1:0], b[7:4]});
        pred_n = 1;
        enc_carry = b[3:0];
        enc_phase = Phase2;
      end
      Phase2: begin
        pred_chars[0] = url_symbol({enc_carry, b[7:6]});
        pred_chars[1] = url_symbol(b[5:0]);
        pred_n = 2;
        enc_carry = 4'd0;
        enc_phase = Phase0;
      end
      default: begin
        pred_chars[0] = url_symbol(b[7:2]);
        pred_n = 1;
        enc_carry = {2'b00, b[1:0]};
        enc_phase = Phase1;
      end
    endcase
    if (eom) begin
      // flush a partial group and pad out to four characters
      if (enc_phase == Phase1) begin
        pred_chars[1] = url_symbol({enc_carry[1:0], 4'd0});
        pred_chars[2] = PadChar;
        pred_chars[3] = PadChar;
        pred_n = 4;
      end else if (enc_phase == Phase2) begin
        pred_chars[1] = url_symbol({enc_carry, 2'b00});
        pred_chars[2] = PadChar;
        pred_n = 3;
      end
      enc_phase = Phase0;
      enc_carry = 4'd0;
    end
  endfunction

  task automatic note_mismatch(input string what, input enc_char_t exp_c, input enc_char_t act_c);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("mismatch (%s) at char %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
               what, chars_checked, exp_c.ch, exp_c.last, act_c.ch, act_c.last);
  endtask

  // Predict on every accepted byte, check every accepted character.
  always @(posedge clk_i) begin
    enc_char_t exp_c;
    enc_char_t act_c;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        encode_byte(data_byte_i, end_of_message_i);
        if (row_typed_n != 3'd0) begin
          for (int i = 0; i < row_typed_n; i++)
            pending_chars.push_back('{row_typed[31 - 8 * i -: 8],
                                      end_of_message_i && i == row_typed_n - 1});
        end else begin
          for (int i = 0; i < pred_n; i++)
            pending_chars.push_back('{pred_chars[i], end_of_message_i && i == pred_n - 1});
        end
        if (end_of_message_i) msgs_seen++;
      end
      if (out_valid_o && out_ready_i) begin
        act_c = '{out_char_o, last_char_o};
        if (pending_chars.size() == 0) begin
          note_mismatch("unexpected", '0, act_c);
        end else begin
          exp_c = pending_chars.pop_front();
          if (exp_c != act_c) note_mismatch("field", exp_c, act_c);
        end
        chars_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycle_count, pending_chars.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Character sink: random stalls, one long hold-off, one stretch always ready.
  initial begin
    out_ready_i = 1'b0;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && chars_checked >= 60) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      out_ready_i <= (chars_checked >= 250 && chars_checked < 400) ||
                     $urandom_range(0, 99) >= 21;
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic eom, input logic [2:0] tn,
                            input logic [31:0] tv);
    while (!sender_calm && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_message_i <= eom;
    row_typed_n = tn;
    row_typed = tv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every predicted character has come out.
  task automatic drain_output();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_chars.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int         msg_len;
    logic [7:0] fill_byte;
    bit         paused_mid;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = 8'h00;
    end_of_message_i = 1'b0;
    row_typed_n = 3'd0;
    row_typed = 32'h0;
    sender_calm = 1'b0;
    paused_mid = 1'b0;
    bytes_sent = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++)
      offer_byte(DirRows[i].data, DirRows[i].eom, DirRows[i].typed_n, DirRows[i].typed);
    drain_output();

    while (bytes_sent < TotalBytes) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
      for (int k = 0; k < msg_len; k++) begin
        if ($urandom_range(0, 7) == 0) fill_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else fill_byte = 8'($urandom_range(0, 255));
        sender_calm = (bytes_sent >= 180 && bytes_sent < 240);
        offer_byte(fill_byte, k == msg_len - 1, 3'd0, 32'h0);
      end
      if (!paused_mid && bytes_sent >= 120) begin
        paused_mid = 1'b1;
        drain_output();
      end
    end

    drain_output();
    repeat (20) @(posedge clk_i);
    $display("encoded %0d bytes in %0d messages, checked %0d characters",
             bytes_sent, msgs_seen, chars_checked);
    $display("%0d mismatches over %0d cycles, including one %0d-cycle output hold-off",
             mismatches, cycle_count, HoldOffCycles);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
